FILE: hw/rtl/mpsr_pkg.sv
// Shared definitions of the multi-party slot reservation block.
// Field widths, result status codes and the controller/datapath command and status structs.
// Depends on nothing; every other file of the block imports it.
package mpsr_pkg;

	// Default sizes of the slot store and the attendee list
	localparam int unsigned NUM_USERS_DEF     = 64;
	localparam int unsigned NUM_DAYS_DEF      = 64;
	localparam int unsigned MAX_ATTENDEES_DEF = 8;

	// Item field widths
	localparam int unsigned USER_W   = 6;
	localparam int unsigned DAY_W    = 6;
	localparam int unsigned HOUR_W   = 5;
	localparam int unsigned MIN_W    = 6;
	localparam int unsigned DUR_W    = 11;
	localparam int unsigned STATUS_W = 2;

	// One free-slot word covers 64 half-hour slots of a day
	localparam int unsigned SLOT_W     = 64;
	localparam int unsigned SLOT_CNT_W = 7;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_BOOKED   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_CONFLICT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SPAN     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_LIMIT    = 2'd3;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic clear;    // write one all-free word of the clearing pass
		logic take;     // an item is accepted this cycle
		logic acc;      // fold the word read for the item into the running AND
		logic check;    // decide the group result
		logic pend_rd;  // read the next pending attendee
		logic word_rd;  // read that attendee's slot word
		logic word_wr;  // write the cleared word back
		logic emit;     // load the result register and close the group
	} mpsr_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic clear_done;   // last word of the clearing pass is being written
		logic last;         // the item in flight ends its group
		logic booked_ok;    // the group passes every check
		logic commit_last;  // the write-back covers the last pending attendee
		logic out_free;     // the result register can take a new result
	} mpsr_sts_t;

endpackage

FILE: hw/rtl/mpsr_if.sv
// Handshake channels of the slot reservation block: attendee items in, group results out.
// Depends on mpsr_pkg for the field widths.

interface mpsr_item_if import mpsr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [USER_W-1:0] user_id;
	logic [DAY_W-1:0]  day_index;
	logic [HOUR_W-1:0] start_hour;
	logic [MIN_W-1:0]  start_minute;
	logic [DUR_W-1:0]  duration_minutes;
	logic              last_attendee;

	modport source (output valid, user_id, day_index, start_hour, start_minute,
		duration_minutes, last_attendee, input ready);
	modport sink (input valid, user_id, day_index, start_hour, start_minute,
		duration_minutes, last_attendee, output ready);
endinterface

interface mpsr_result_if import mpsr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                booked;
	logic [STATUS_W-1:0] status;

	modport source (output valid, booked, status, input ready);
	modport sink (input valid, booked, status, output ready);
endinterface

FILE: hw/rtl/mpsr_ctrl.sv
// Controller of the slot reservation block: sequences clearing, item intake, check and commit.
// Depends on mpsr_pkg for the command and status structs.
module mpsr_ctrl import mpsr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  mpsr_sts_t sts,
	output mpsr_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ACC,
		S_CHECK,
		S_PEND,
		S_READ,
		S_WRITE,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	assign item_ready = (state_q == S_IDLE);

	// Decode commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (item_valid) begin
					cmd.take = 1'b1;
					state_d  = S_ACC;
				end
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.last ? S_CHECK : S_IDLE;
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_d   = sts.booked_ok ? S_PEND : S_EMIT;
			end
			S_PEND: begin
				cmd.pend_rd = 1'b1;
				state_d     = S_READ;
			end
			S_READ: begin
				cmd.word_rd = 1'b1;
				state_d     = S_WRITE;
			end
			S_WRITE: begin
				cmd.word_wr = 1'b1;
				state_d     = sts.commit_last ? S_EMIT : S_PEND;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hw/rtl/mpsr_dp.sv
// Datapath of the slot reservation block: slot word memory, pending attendee list,
// group registers and the result register. Depends on mpsr_pkg; driven by mpsr_ctrl.
module mpsr_dp import mpsr_pkg::*; #(
	parameter int unsigned NUM_USERS     = NUM_USERS_DEF,
	parameter int unsigned NUM_DAYS      = NUM_DAYS_DEF,
	parameter int unsigned MAX_ATTENDEES = MAX_ATTENDEES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mpsr_cmd_t           cmd,
	output mpsr_sts_t           sts,
	input  logic [USER_W-1:0]   item_user_id,
	input  logic [DAY_W-1:0]    item_day_index,
	input  logic [HOUR_W-1:0]   item_start_hour,
	input  logic [MIN_W-1:0]    item_start_minute,
	input  logic [DUR_W-1:0]    item_duration_minutes,
	input  logic                item_last_attendee,
	output logic                result_valid,
	input  logic                result_ready,
	output logic                result_booked,
	output logic [STATUS_W-1:0] result_status
);

	localparam int unsigned DEPTH = NUM_USERS * NUM_DAYS;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned UW    = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
	localparam int unsigned DW    = (NUM_DAYS > 1) ? $clog2(NUM_DAYS) : 1;
	localparam int unsigned CW    = $clog2(MAX_ATTENDEES + 1);
	localparam int unsigned PW    = (MAX_ATTENDEES > 1) ? $clog2(MAX_ATTENDEES) : 1;
	localparam int unsigned TBL_W = 12;
	localparam int unsigned TBL_N = 64;

	// floor(d/30) for d < 2048 as (d * 2185) >> 16
	localparam int unsigned DIV30_MUL = 2185;
	localparam int unsigned MUL_W     = 12;
	localparam int unsigned PROD_W    = DUR_W + MUL_W;
	localparam int unsigned HALF_HOUR = 30;
	localparam int unsigned DAY_SLOTS = SLOT_W;

	typedef logic [TBL_N-1:0][TBL_W-1:0] mod_tbl_t;

	// Residue table of a 6-bit index modulo n, built by counting
	function automatic mod_tbl_t mod_table(input int unsigned n);
		mod_tbl_t    tbl;
		int unsigned r;
		r = 0;
		for (int i = 0; i < TBL_N; i++) begin
			tbl[i] = TBL_W'(r);
			if (r + 1 == n) begin
				r = 0;
			end else begin
				r = r + 1;
			end
		end
		return tbl;
	endfunction

	localparam mod_tbl_t USER_TBL = mod_table(NUM_USERS);
	localparam mod_tbl_t DAY_TBL  = mod_table(NUM_DAYS);

	localparam logic [AW-1:0] DAYS_A = AW'(NUM_DAYS);
	localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);

	function automatic logic [AW-1:0] word_addr(input logic [UW-1:0] u, input logic [DW-1:0] d);
		return AW'(u) * DAYS_A + AW'(d);
	endfunction

	// Memories
	logic [SLOT_W-1:0] slot_mem [DEPTH];
	logic [UW-1:0]     pend_mem [MAX_ATTENDEES];

	// Group and control registers
	logic                  in_group_q;
	logic                  first_q;
	logic                  use_rd_q;
	logic                  last_q;
	logic                  span_bad_q;
	logic                  over_limit_q;
	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         k_q;
	logic [AW-1:0]         clr_q;
	logic [DW-1:0]         group_day_q;
	logic [SLOT_W-1:0]     running_q;
	logic [SLOT_W-1:0]     mask_q;
	logic [SLOT_CNT_W-1:0] start_q;
	logic [SLOT_CNT_W-1:0] count_q;
	logic [STATUS_W-1:0]   res_q;
	logic [UW-1:0]         pu_q;
	logic [SLOT_W-1:0]     rd_word_q;
	logic                  out_valid_q;
	logic [STATUS_W-1:0]   out_status_q;

	// Item decode
	logic [UW-1:0]         user_mod;
	logic [DW-1:0]         day_mod;
	logic [DW-1:0]         day_sel;
	logic [1:0]            min_div;
	logic [PROD_W-1:0]     dur_prod;
	logic [SLOT_CNT_W-1:0] start_in;
	logic [SLOT_CNT_W-1:0] count_in;
	logic                  room;
	logic [SLOT_CNT_W:0]   span_end;
	logic [SLOT_W-1:0]     mask_calc;
	logic [STATUS_W-1:0]   code;

	// Memory port controls
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [SLOT_W-1:0] wr_data;
	logic [AW-1:0]     addr_item;
	logic [AW-1:0]     addr_commit;

	assign user_mod = USER_TBL[item_user_id][UW-1:0];
	assign day_mod  = DAY_TBL[item_day_index][DW-1:0];
	assign day_sel  = in_group_q ? group_day_q : day_mod;

	// Start slot and slot count of the group's first item
	assign min_div  = (item_start_minute >= MIN_W'(2 * HALF_HOUR)) ? 2'd2 :
		(item_start_minute >= MIN_W'(HALF_HOUR)) ? 2'd1 : 2'd0;
	assign start_in = {1'b0, item_start_hour, 1'b0} + SLOT_CNT_W'(min_div);
	assign dur_prod = PROD_W'(item_duration_minutes) * PROD_W'(DIV30_MUL);
	assign count_in = dur_prod[PROD_W-1 -: SLOT_CNT_W];

	assign room      = (cnt_q < CW'(MAX_ATTENDEES));
	assign span_end  = {1'b0, start_q} + {1'b0, count_q};
	assign mask_calc = ((SLOT_W'(1) << count_q) - SLOT_W'(1)) << start_q;

	// Group verdict, in priority order
	always_comb begin
		if (over_limit_q) begin
			code = ST_LIMIT;
		end else if (span_bad_q) begin
			code = ST_SPAN;
		end else if ((running_q & mask_q) != mask_q) begin
			code = ST_CONFLICT;
		end else begin
			code = ST_BOOKED;
		end
	end

	assign addr_item   = word_addr(user_mod, day_sel);
	assign addr_commit = word_addr(pu_q, group_day_q);

	assign rd_en   = (cmd.take && room) || cmd.word_rd;
	assign rd_addr = cmd.take ? addr_item : addr_commit;
	assign wr_en   = cmd.clear || cmd.word_wr;
	assign wr_addr = cmd.clear ? clr_q : addr_commit;
	assign wr_data = cmd.clear ? {SLOT_W{1'b1}} : (rd_word_q & ~mask_q);

	assign sts.clear_done  = (clr_q == LAST_A);
	assign sts.last        = last_q;
	assign sts.booked_ok   = (code == ST_BOOKED);
	assign sts.commit_last = ((k_q + CW'(1)) == cnt_q);
	assign sts.out_free    = !out_valid_q || result_ready;

	assign result_valid  = out_valid_q;
	assign result_status = out_status_q;
	assign result_booked = (out_status_q == ST_BOOKED);

	// Slot word memory: one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_word_q <= slot_mem[rd_addr];
		end
	end

	// Pending attendee list
	always_ff @(posedge clk) begin
		if (cmd.take && room) begin
			pend_mem[cnt_q[PW-1:0]] <= user_mod;
		end
		if (cmd.pend_rd) begin
			pu_q <= pend_mem[k_q[PW-1:0]];
		end
	end

	// Latch the span fields of the group's first item
	always_ff @(posedge clk) begin
		if (cmd.take && !in_group_q) begin
			start_q <= start_in;
			count_q <= count_in;
		end
	end

	// Track the open group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_group_q   <= 1'b0;
			first_q      <= 1'b0;
			use_rd_q     <= 1'b0;
			last_q       <= 1'b0;
			span_bad_q   <= 1'b0;
			over_limit_q <= 1'b0;
			cnt_q        <= '0;
			group_day_q  <= '0;
			running_q    <= {SLOT_W{1'b1}};
			mask_q       <= '0;
		end else begin
			if (cmd.take) begin
				in_group_q <= 1'b1;
				first_q    <= !in_group_q;
				use_rd_q   <= room;
				last_q     <= item_last_attendee;
				if (!in_group_q) begin
					group_day_q <= day_mod;
				end
				if (room) begin
					cnt_q <= cnt_q + CW'(1);
				end else begin
					over_limit_q <= 1'b1;
				end
			end
			if (cmd.acc) begin
				first_q <= 1'b0;
				if (use_rd_q) begin
					running_q <= running_q & rd_word_q;
				end
				if (first_q) begin
					span_bad_q <= (span_end > (SLOT_CNT_W + 1)'(DAY_SLOTS));
					mask_q     <= (span_end > (SLOT_CNT_W + 1)'(DAY_SLOTS)) ? '0 : mask_calc;
				end
			end
			if (cmd.emit) begin
				in_group_q   <= 1'b0;
				span_bad_q   <= 1'b0;
				over_limit_q <= 1'b0;
				cnt_q        <= '0;
				running_q    <= {SLOT_W{1'b1}};
			end
		end
	end

	// Advance the clearing pass and the commit walk; hold the verdict
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			k_q   <= '0;
			res_q <= ST_BOOKED;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.check) begin
				res_q <= code;
				k_q   <= '0;
			end
			if (cmd.word_wr) begin
				k_q <= k_q + CW'(1);
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_status_q <= ST_BOOKED;
		end else begin
			if (cmd.emit) begin
				out_valid_q  <= 1'b1;
				out_status_q <= res_q;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hw/rtl/multi_party_slot_reservation.sv
// Multi-party slot reservation: keeps a 64-bit free-slot word per user and day and books
// half-hour spans for a group of attendees sent one per item, the last one marked.
// After reset a clearing pass writes all NUM_USERS*NUM_DAYS words free (4096 with the
// defaults), one word a cycle, and no item is taken during it. Each attendee item then goes
// through a slot memory read and a fold of the word into the running AND. The last item of a
// group adds a check, a commit per attendee (pending list read, slot word read, write back of
// the cleared word) when the group is booked, and a load of the result register, which waits
// while a prior result is held.
// Depends on mpsr_pkg, mpsr_if, mpsr_ctrl and mpsr_dp.
module multi_party_slot_reservation import mpsr_pkg::*; #(
	parameter int unsigned NUM_USERS     = NUM_USERS_DEF,
	parameter int unsigned NUM_DAYS      = NUM_DAYS_DEF,
	parameter int unsigned MAX_ATTENDEES = MAX_ATTENDEES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	mpsr_item_if.sink     item,
	mpsr_result_if.source result
);

	mpsr_cmd_t cmd;
	mpsr_sts_t sts;
	logic      ready;

	assign item.ready = ready;

	// Sequence the work
	mpsr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// Hold slot words, group state and the result
	mpsr_dp #(
		.NUM_USERS     (NUM_USERS),
		.NUM_DAYS      (NUM_DAYS),
		.MAX_ATTENDEES (MAX_ATTENDEES)
	) u_dp (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cmd                   (cmd),
		.sts                   (sts),
		.item_user_id          (item.user_id),
		.item_day_index        (item.day_index),
		.item_start_hour       (item.start_hour),
		.item_start_minute     (item.start_minute),
		.item_duration_minutes (item.duration_minutes),
		.item_last_attendee    (item.last_attendee),
		.result_valid          (result.valid),
		.result_ready          (result.ready),
		.result_booked         (result.booked),
		.result_status         (result.status)
	);

endmodule

FILE: dv/tb_multi_party_slot_reservation.sv
// Testbench of the multi-party slot reservation block: directed and random attendee groups,
// each result checked against a local model of the free-slot store.
// Depends on mpsr_pkg, mpsr_if and multi_party_slot_reservation.
module tb_multi_party_slot_reservation;
	import mpsr_pkg::*;

	localparam int unsigned WORDS = NUM_USERS_DEF * NUM_DAYS_DEF;

	typedef struct packed {
		logic                booked;
		logic [STATUS_W-1:0] status;
	} outcome_t;

	logic clk;
	logic arst_n;

	mpsr_item_if   item_ch();
	mpsr_result_if result_ch();

	multi_party_slot_reservation uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	// Model of the free-slot store and the open group
	logic [SLOT_W-1:0] free_slots [WORDS];
	logic [USER_W-1:0] grp_members [$];
	logic [SLOT_W-1:0] grp_and;
	logic [SLOT_W-1:0] grp_mask;
	logic [DAY_W-1:0]  grp_day;
	logic              grp_open;
	logic              grp_span_bad;
	logic              grp_over_limit;
	outcome_t          outcomes_due [$];

	int unsigned mismatch_count;
	int unsigned gap_max;
	int unsigned stall_pct;
	int unsigned burst_left;
	int unsigned stall_left = 0;
	logic        sender_holding;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stop a hung run
	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic int unsigned word_addr(input logic [USER_W-1:0] u,
		input logic [DAY_W-1:0] d);
		return (32'(u) % NUM_USERS_DEF) * NUM_DAYS_DEF + (32'(d) % NUM_DAYS_DEF);
	endfunction

	// Fold one accepted attendee into the open group; on the last one decide the outcome
	function automatic void reserve_attendee(input logic [USER_W-1:0] u,
		input logic [DAY_W-1:0] d, input logic [HOUR_W-1:0] h, input logic [MIN_W-1:0] m,
		input logic [DUR_W-1:0] dur, input logic last);
		int unsigned first_slot;
		int unsigned n_slots;
		outcome_t    res;
		// latch day and span from the first attendee
		if (!grp_open) begin
			first_slot = 32'(h) * 2 + 32'(m) / 30;
			n_slots = 32'(dur) / 30;
			grp_day = d;
			grp_open = 1'b1;
			grp_mask = '0;
			if (first_slot + n_slots > SLOT_W) begin
				grp_span_bad = 1'b1;
			end else if (n_slots == SLOT_W) begin
				grp_mask = '1;
			end else if (n_slots != 0) begin
				grp_mask = ((64'd1 << n_slots) - 64'd1) << first_slot;
			end
		end
		// hold the attendee, or flag the group once the list is full
		if (grp_members.size() < MAX_ATTENDEES_DEF) begin
			grp_members.push_back(u);
			grp_and &= free_slots[word_addr(u, grp_day)];
		end else begin
			grp_over_limit = 1'b1;
		end
		if (!last) return;
		if (grp_over_limit) begin
			res = '{booked: 1'b0, status: ST_LIMIT};
		end else if (grp_span_bad) begin
			res = '{booked: 1'b0, status: ST_SPAN};
		end else if ((grp_and & grp_mask) != grp_mask) begin
			res = '{booked: 1'b0, status: ST_CONFLICT};
		end else begin
			foreach (grp_members[k]) begin
				free_slots[word_addr(grp_members[k], grp_day)] &= ~grp_mask;
			end
			res = '{booked: 1'b1, status: ST_BOOKED};
		end
		outcomes_due.push_back(res);
		grp_members.delete();
		grp_and = '1;
		grp_open = 1'b0;
		grp_span_bad = 1'b0;
		grp_over_limit = 1'b0;
	endfunction

	// Offer one item, wait for it to be taken, then maybe idle between bursts
	task automatic send_item(input logic [USER_W-1:0] u, input logic [DAY_W-1:0] d,
		input logic [HOUR_W-1:0] h, input logic [MIN_W-1:0] m, input logic [DUR_W-1:0] dur,
		input logic last);
		item_ch.valid <= 1'b1;
		item_ch.user_id <= u;
		item_ch.day_index <= d;
		item_ch.start_hour <= h;
		item_ch.start_minute <= m;
		item_ch.duration_minutes <= dur;
		item_ch.last_attendee <= last;
		sender_holding = 1'b1;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		reserve_attendee(u, d, h, m, dur, last);
		if (gap_max != 0) begin
			if (burst_left != 0) burst_left--;
			if (burst_left == 0) begin
				item_ch.valid <= 1'b0;
				sender_holding = 1'b0;
				repeat ($urandom_range(1, gap_max)) @(posedge clk);
				burst_left = $urandom_range(1, 12);
			end
		end
	endtask

	// Check each result taken and drive the result stall pattern
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (outcomes_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: booked=%0b status=%0d",
						result_ch.booked, result_ch.status);
			end else begin
				want = outcomes_due.pop_front();
				if (result_ch.booked !== want.booked || result_ch.status !== want.status) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("expected booked=%0b status=%0d, got booked=%0b status=%0d",
							want.booked, want.status, result_ch.booked, result_ch.status);
				end
			end
		end
		if (stall_left != 0) begin
			result_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			result_ch.ready <= 1'b1;
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
				stall_left = $urandom_range(1, 6);
		end
	end

	// Field extremes, each status code, empty and full masks, repeats and oversize groups
	task automatic test_directed_cases();
		gap_max = 0;
		stall_pct = 0;
		send_item(0, 0, 0, 0, 30, 1'b1);
		send_item(0, 0, 0, 0, 30, 1'b1);
		send_item(0, 0, 0, 29, 60, 1'b1);
		send_item(5, 1, 0, 0, 0, 1'b1);
		send_item(63, 63, 0, 0, 1920, 1'b1);
		send_item(63, 63, 0, 0, 0, 1'b1);
		send_item(63, 63, 23, 30, 30, 1'b1);
		send_item(1, 2, 23, 59, 1440, 1'b1);
		send_item(1, 2, 31, 63, 0, 1'b1);
		send_item(1, 2, 31, 63, 30, 1'b1);
		send_item(1, 2, 0, 0, 2047, 1'b1);
		// same attendee twice in one group
		send_item(2, 3, 10, 30, 90, 1'b0);
		send_item(3, 63, 31, 63, 2047, 1'b0);
		send_item(2, 0, 0, 0, 0, 1'b1);
		// one attendee already busy in the span
		send_item(3, 3, 11, 0, 30, 1'b0);
		send_item(4, 0, 0, 0, 0, 1'b1);
		// one attendee past the limit, bad span as well
		for (int k = 0; k < 9; k++)
			send_item(USER_W'(10 + k), DAY_W'((k == 0) ? 5 : $urandom), 31, 63, 2047,
				k == 8);
	endtask

	// Generate well-formed groups with random content under the current idling
	task automatic run_groups(input int unsigned item_budget);
		int unsigned       sent;
		int unsigned       size;
		int unsigned       pick;
		logic              narrow;
		logic [USER_W-1:0] u;
		logic [DAY_W-1:0]  d;
		logic [HOUR_W-1:0] h;
		logic [MIN_W-1:0]  m;
		logic [DUR_W-1:0]  dur;
		sent = 0;
		while (sent < item_budget) begin
			narrow = ($urandom_range(0, 3) != 0);
			size = ($urandom_range(0, 19) == 0) ? $urandom_range(MAX_ATTENDEES_DEF + 1, 11)
				: $urandom_range(1, MAX_ATTENDEES_DEF);
			d = DAY_W'(narrow ? $urandom_range(0, 3) : $urandom);
			h = HOUR_W'(($urandom_range(0, 19) == 0) ? $urandom_range(24, 31)
				: $urandom_range(0, 23));
			m = MIN_W'(($urandom_range(0, 19) == 0) ? $urandom_range(60, 63)
				: $urandom_range(0, 59));
			pick = $urandom_range(0, 9);
			dur = DUR_W'((pick < 7) ? $urandom_range(0, 240)
				: (pick < 9) ? $urandom_range(0, 1440) : $urandom);
			for (int k = 0; k < size; k++) begin
				u = USER_W'(narrow ? $urandom_range(0, 7) : $urandom);
				if (k == 0)
					send_item(u, d, h, m, dur, size == 1);
				else
					send_item(u, DAY_W'($urandom), HOUR_W'($urandom), MIN_W'($urandom),
						DUR_W'($urandom), k == size - 1);
			end
			sent += size;
		end
	endtask

	task automatic test_group_bookings();
		gap_max = 8;
		stall_pct = 25;
		burst_left = 0;
		run_groups(250);
	endtask

	// Fully random fields; group ends fall at random, so oversize groups show up
	task automatic test_malformed_groups(input int unsigned item_budget);
		gap_max = 4;
		stall_pct = 50;
		for (int k = 0; k < item_budget; k++)
			send_item(USER_W'($urandom), DAY_W'($urandom), HOUR_W'($urandom),
				MIN_W'($urandom), DUR_W'($urandom), $urandom_range(0, 3) == 0);
		send_item(USER_W'($urandom), DAY_W'($urandom), HOUR_W'($urandom),
			MIN_W'($urandom), DUR_W'($urandom), 1'b1);
	endtask

	task automatic test_back_to_back();
		gap_max = 0;
		stall_pct = 0;
		run_groups(50);
	endtask

	// Keep results waiting so the result register backs up into the item side
	task automatic test_stalled_results();
		gap_max = 0;
		stall_pct = 70;
		run_groups(40);
	endtask

	initial begin
		int unsigned waited;
		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.user_id <= '0;
		item_ch.day_index <= '0;
		item_ch.start_hour <= '0;
		item_ch.start_minute <= '0;
		item_ch.duration_minutes <= '0;
		item_ch.last_attendee <= 1'b0;
		mismatch_count = 0;
		gap_max = 0;
		stall_pct = 0;
		burst_left = 0;
		sender_holding = 1'b0;
		foreach (free_slots[i]) free_slots[i] = '1;
		grp_and = '1;
		grp_mask = '0;
		grp_day = '0;
		grp_open = 1'b0;
		grp_span_bad = 1'b0;
		grp_over_limit = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_group_bookings();
		test_malformed_groups(60);
		test_back_to_back();
		test_stalled_results();

		// drop valid and let outstanding results drain
		if (sender_holding) item_ch.valid <= 1'b0;
		waited = 0;
		while (outcomes_due.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (60) @(posedge clk);

		if (mismatch_count == 0 && outcomes_due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
